### sv/lcal_pkg.sv
// ----------------------------------------------------------------------------
// Lowest common ancestor package
// Sizes, command codes and node helpers for the binary-lifting LCA engine.
// ----------------------------------------------------------------------------
`default_nettype none

package lcal_pkg;

	// Width of a node number or a depth on the stream.
	localparam int NODE_W    = 10;
	// Highest node number that the tables hold.
	localparam int MAX_NODES = 1023;
	// Number of lifting levels: level k holds the 2^k-th ancestor.
	localparam int LEVELS    = 10;
	localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	// Ancestor table address is {level, node}.
	localparam int ANC_DEPTH = LEVELS * (1 << NODE_W);

	// Command codes carried in tuser.
	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_BUILD = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;
	localparam logic [1:0] CMD_NOP   = 2'd3;

	typedef logic [NODE_W-1:0] node_t;
	typedef logic [LVL_W-1:0]  lvl_t;

	// A node number beyond the table counts as the null node.
	function automatic node_t clamp_node(input node_t v);
		return (v > MAX_NODES) ? '0 : v;
	endfunction

endpackage

`default_nettype wire

### sv/lowest_common_ancestor_lifting.sv
// ----------------------------------------------------------------------------
// Lowest common ancestor engine, binary lifting
// Loads parents and depths, builds the ancestor table and answers LCA queries.
// ----------------------------------------------------------------------------
// The block takes one command per transfer on the slave stream, with the
// command code in s_tuser. A load stores one node's parent and depth; node
// zero is the null node and a load of it is ignored. A build fills levels 1
// to LEVELS-1 of the ancestor table for nodes 1 up to node_count, with one
// read, a second read and a write per entry, the two reads through the
// single read port of the table. A query returns one transfer on the master
// stream holding the lowest common ancestor. It reads both depths, then per
// level in the depth phase either moves on (no lift) or reads and lifts,
// then either goes straight to the output when the two nodes already match
// or steps through all levels of the common ascent and a last step to the
// parent, then passes the answer to the output register; the ancestor table
// read port is what paces it. The block is busy, with s_tready low, from the
// transfer of a build or query until it is done; a pending result only holds
// the block if a second result is ready before the first has been taken. The
// tables are not cleared at reset: every node that a build or query touches
// must have been loaded first. node_count may only be written while the block
// is idle.
`default_nettype none

module lowest_common_ancestor_lifting (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration: node_count
	input  wire logic        cfg_wr_en,
	input  wire logic [9:0]  cfg_wr_data,
	// Command stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // node[9:0], parent_node[19:10],
	                                     // node_depth[29:20], other_node[39:30]
	input  wire logic [1:0]  s_tuser,   // cmd[1:0]
	// Result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata    // ancestor[9:0], zero above
);

	localparam int NW = lcal_pkg::NODE_W;
	localparam int LW = lcal_pkg::LVL_W;

	// Sequencer states.
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_B_RD1 = 4'd1;
	localparam logic [3:0] S_B_RD2 = 4'd2;
	localparam logic [3:0] S_B_WR  = 4'd3;
	localparam logic [3:0] S_Q_D0  = 4'd4;
	localparam logic [3:0] S_Q_D1  = 4'd5;
	localparam logic [3:0] S_Q_L1  = 4'd6;
	localparam logic [3:0] S_Q_L2  = 4'd7;
	localparam logic [3:0] S_Q_L3  = 4'd8;
	localparam logic [3:0] S_Q_U1  = 4'd9;
	localparam logic [3:0] S_Q_U2  = 4'd10;
	localparam logic [3:0] S_Q_U3  = 4'd11;
	localparam logic [3:0] S_Q_FIN = 4'd12;
	localparam logic [3:0] S_Q_F2  = 4'd13;
	localparam logic [3:0] S_OUT   = 4'd14;

	localparam lcal_pkg::lvl_t TOP_LVL = LW'(lcal_pkg::LEVELS - 1);

	// Input fields.
	lcal_pkg::node_t in_node, in_parent, in_depth, in_other;
	logic [1:0]      in_cmd;

	assign in_node   = s_tdata[NW-1:0];
	assign in_parent = s_tdata[2*NW-1:NW];
	assign in_depth  = s_tdata[3*NW-1:2*NW];
	assign in_other  = s_tdata[4*NW-1:3*NW];
	assign in_cmd    = s_tuser;

	// Control registers.
	logic [3:0]      state_q;
	lcal_pkg::node_t node_count_q;
	logic            m_tvalid_q;

	// Working registers.
	lcal_pkg::lvl_t  k_q;
	lcal_pkg::node_t n_q, last_q;
	lcal_pkg::node_t a_q, b_q, da_q, db_q, up_q;

	// Memories and their read registers.
	lcal_pkg::node_t anc_mem [lcal_pkg::ANC_DEPTH];
	lcal_pkg::node_t dep_mem [1 << NW];
	lcal_pkg::node_t anc_rdata_q, dep0_rdata_q, dep1_rdata_q;
	logic            anc_zero_q, dep0_zero_q, dep1_zero_q;

	// Shared port controls.
	logic            anc_rd_en, anc_wr_en;
	lcal_pkg::lvl_t  anc_rd_lvl, anc_wr_lvl;
	lcal_pkg::node_t anc_rd_node, anc_wr_node, anc_wr_data;
	logic            dep0_rd_en, dep1_rd_en;
	lcal_pkg::node_t dep0_rd_node;

	// Node zero reads as zero in both tables: it is never written.
	lcal_pkg::node_t anc_rval, dep0_val, dep1_val;
	assign anc_rval = anc_zero_q  ? '0 : anc_rdata_q;
	assign dep0_val = dep0_zero_q ? '0 : dep0_rdata_q;
	assign dep1_val = dep1_zero_q ? '0 : dep1_rdata_q;

	logic in_xfer;
	assign in_xfer  = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);

	logic load_ok;
	assign load_ok = in_xfer && (in_cmd == lcal_pkg::CMD_LOAD) && (in_node != '0) &&
		(in_node <= lcal_pkg::MAX_NODES);

	// Build range: node_count limited to the table size.
	lcal_pkg::node_t build_last;
	assign build_last = (node_count_q > lcal_pkg::MAX_NODES) ?
		NW'(lcal_pkg::MAX_NODES) : node_count_q;

	// Depth phase: lift b by 2^k when the depth gap allows it.
	lcal_pkg::node_t diff;
	logic            lift;
	assign diff = (db_q >= da_q) ? (db_q - da_q) : '0;
	assign lift = (int'(k_q) < NW) && ((diff >> k_q) != '0);

	logic out_free;
	assign out_free = !m_tvalid_q || m_tready;

	// Read and write port selection for the sequencer.
	always_comb begin
		anc_rd_en    = 1'b0;
		anc_rd_lvl   = k_q;
		anc_rd_node  = a_q;
		anc_wr_en    = 1'b0;
		anc_wr_lvl   = k_q;
		anc_wr_node  = n_q;
		anc_wr_data  = anc_rval;
		dep0_rd_en   = 1'b0;
		dep0_rd_node = a_q;
		dep1_rd_en   = 1'b0;
		case (state_q)
			S_IDLE: begin
				// A load writes level zero directly.
				anc_wr_en   = load_ok;
				anc_wr_lvl  = '0;
				anc_wr_node = in_node;
				anc_wr_data = lcal_pkg::clamp_node(in_parent);
			end
			S_B_RD1: begin
				anc_rd_en   = 1'b1;
				anc_rd_lvl  = k_q - 1'b1;
				anc_rd_node = n_q;
			end
			S_B_RD2: begin
				anc_rd_en   = 1'b1;
				anc_rd_lvl  = k_q - 1'b1;
				anc_rd_node = anc_rval;
			end
			S_B_WR: begin
				anc_wr_en = 1'b1;
			end
			S_Q_D0: begin
				dep0_rd_en = 1'b1;
				dep1_rd_en = 1'b1;
			end
			S_Q_L1: begin
				anc_rd_en   = lift;
				anc_rd_node = b_q;
			end
			S_Q_L2: begin
				dep0_rd_en   = 1'b1;
				dep0_rd_node = anc_rval;
			end
			S_Q_U1: begin
				anc_rd_en = (a_q != b_q);
			end
			S_Q_U2: begin
				anc_rd_en   = 1'b1;
				anc_rd_node = b_q;
			end
			S_Q_FIN: begin
				anc_rd_en  = (a_q != b_q);
				anc_rd_lvl = '0;
			end
			default: begin
			end
		endcase
	end

	// Ancestor table: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (anc_wr_en) begin
			anc_mem[{anc_wr_lvl, anc_wr_node}] <= anc_wr_data;
		end
		if (anc_rd_en) begin
			anc_rdata_q <= anc_mem[{anc_rd_lvl, anc_rd_node}];
			anc_zero_q  <= (anc_rd_node == '0);
		end
	end

	// Depth table: one write and two registered reads.
	always_ff @(posedge clk) begin
		if (load_ok) begin
			dep_mem[in_node] <= in_depth;
		end
		if (dep0_rd_en) begin
			dep0_rdata_q <= dep_mem[dep0_rd_node];
			dep0_zero_q  <= (dep0_rd_node == '0);
		end
		if (dep1_rd_en) begin
			dep1_rdata_q <= dep_mem[b_q];
			dep1_zero_q  <= (b_q == '0);
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			node_count_q <= NW'(1);
			m_tvalid_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				node_count_q <= cfg_wr_data;
			end
			if (state_q == S_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer && in_cmd == lcal_pkg::CMD_BUILD &&
						build_last != '0 && lcal_pkg::LEVELS > 1) begin
						state_q <= S_B_RD1;
					end else if (in_xfer && in_cmd == lcal_pkg::CMD_QUERY) begin
						state_q <= S_Q_D0;
					end
				end
				S_B_RD1: state_q <= S_B_RD2;
				S_B_RD2: state_q <= S_B_WR;
				S_B_WR: begin
					state_q <= (n_q == last_q && k_q == TOP_LVL) ? S_IDLE : S_B_RD1;
				end
				S_Q_D0: state_q <= S_Q_D1;
				S_Q_D1: state_q <= S_Q_L1;
				S_Q_L1: begin
					if (lift) begin
						state_q <= S_Q_L2;
					end else if (k_q == '0) begin
						state_q <= S_Q_U1;
					end
				end
				S_Q_L2: state_q <= S_Q_L3;
				S_Q_L3: state_q <= (k_q == '0) ? S_Q_U1 : S_Q_L1;
				S_Q_U1: state_q <= (a_q == b_q) ? S_OUT : S_Q_U2;
				S_Q_U2: state_q <= S_Q_U3;
				S_Q_U3: state_q <= (k_q == '0) ? S_Q_FIN : S_Q_U1;
				S_Q_FIN: state_q <= (a_q == b_q) ? S_OUT : S_Q_F2;
				S_Q_F2: state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working registers of the build and the query walk.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				k_q    <= LW'(1);
				n_q    <= NW'(1);
				last_q <= build_last;
				a_q    <= lcal_pkg::clamp_node(in_node);
				b_q    <= lcal_pkg::clamp_node(in_other);
			end
			S_B_WR: begin
				if (n_q == last_q) begin
					n_q <= NW'(1);
					k_q <= k_q + 1'b1;
				end else begin
					n_q <= n_q + 1'b1;
				end
			end
			S_Q_D1: begin
				// Keep the shallower node in a.
				k_q <= TOP_LVL;
				if (dep0_val > dep1_val) begin
					a_q  <= b_q;
					b_q  <= a_q;
					da_q <= dep1_val;
					db_q <= dep0_val;
				end else begin
					da_q <= dep0_val;
					db_q <= dep1_val;
				end
			end
			S_Q_L1: begin
				if (!lift) begin
					k_q <= (k_q == '0) ? TOP_LVL : k_q - 1'b1;
				end
			end
			S_Q_L2: up_q <= anc_rval;
			S_Q_L3: begin
				if (da_q <= dep0_val) begin
					b_q  <= up_q;
					db_q <= dep0_val;
				end
				k_q <= (k_q == '0) ? TOP_LVL : k_q - 1'b1;
			end
			S_Q_U2: up_q <= anc_rval;
			S_Q_U3: begin
				if (up_q != anc_rval) begin
					a_q <= up_q;
					b_q <= anc_rval;
				end
				if (k_q != '0) begin
					k_q <= k_q - 1'b1;
				end
			end
			S_Q_F2: a_q <= anc_rval;
			default: begin
			end
		endcase
	end

	// Output register; the answer waits in a_q until the slot is free.
	logic [NW-1:0] m_data_q;
	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			m_data_q <= a_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(16 - NW){1'b0}}, m_data_q};

	// Node zero is the null node and must never be written.
	a_anc_no_null_write: assert property (@(posedge clk) disable iff (!arst_n)
		anc_wr_en |-> anc_wr_node != '0)
		else $error("ancestor table write to node zero");

	// Build writes stay inside levels 1.. and nodes 1..last.
	a_build_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_B_WR) |-> (k_q != '0 && n_q != '0 && n_q <= last_q))
		else $error("build index out of range");

	// After the depth phase the deeper node is never above the shallower one.
	a_depth_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_Q_U1) |-> db_q >= da_q)
		else $error("depth order lost in query walk");

	// A result only appears from the output state of a query.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q) == S_OUT)
		else $error("result without a finished query");

endmodule

`default_nettype wire

### verif/testbench.sv
// ----------------------------------------------------------------------------
// Lowest common ancestor engine testbench
// Drives load, build, query and idle commands with random stalls on both
// streams and checks every answer against a predictor kept in the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

	// One command as it travels on the slave stream.
	typedef struct packed {
		logic [1:0]      cmd;
		lcal_pkg::node_t node;
		lcal_pkg::node_t parent;
		lcal_pkg::node_t depth;
		lcal_pkg::node_t other;
	} lca_cmd_t;

	// Length of the long path: its deepest node sits at depth 512, so the
	// depth phase uses every lifting level.
	localparam int CHAIN_NODES = 513;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        cfg_wr_en   = 1'b0;
	logic [9:0]  cfg_wr_data = '0;
	logic        s_tvalid    = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata     = '0;
	logic [1:0]  s_tuser     = lcal_pkg::CMD_NOP;
	logic        m_tvalid;
	logic        m_tready    = 1'b0;
	logic [15:0] m_tdata;

	lowest_common_ancestor_lifting dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------------
	// Predictor state: the bench's own copy of both tables and the node count.
	// Every entry starts at zero, which also covers the null node.
	// ------------------------------------------------------------------------
	bit [lcal_pkg::NODE_W-1:0] lift_tbl [0:lcal_pkg::LEVELS-1][0:lcal_pkg::MAX_NODES];
	bit [lcal_pkg::NODE_W-1:0] depth_tbl [0:lcal_pkg::MAX_NODES];
	int unsigned               node_limit = 1;

	// Commands waiting for the driver, and answers waiting for the monitor.
	lca_cmd_t        pending_cmds [$];
	lcal_pkg::node_t expected_lca [$];

	// Depths of the tree as the stimulus generator planted it.
	int unsigned plan_depth [0:lcal_pkg::MAX_NODES];

	int mismatches = 0;

	// A node number beyond the table stands for the null node.
	function automatic lcal_pkg::node_t null_if_out(input lcal_pkg::node_t v);
		return (int'(v) > lcal_pkg::MAX_NODES) ? '0 : v;
	endfunction

	// Binary-lifting walk over the predicted tables.
	function automatic lcal_pkg::node_t lca_of(input lcal_pkg::node_t a_in,
		input lcal_pkg::node_t b_in);
		lcal_pkg::node_t a;
		lcal_pkg::node_t b;
		lcal_pkg::node_t t;
		lcal_pkg::node_t up;
		int              diff;
		int              k;
		a = a_in;
		b = b_in;
		// Keep b as the deeper of the two.
		if (depth_tbl[a] > depth_tbl[b]) begin
			t = a;
			a = b;
			b = t;
		end
		// Lift b towards the depth of a. A lift that would overshoot a is
		// refused, which keeps the walk finite when depths are inconsistent.
		for (k = lcal_pkg::LEVELS - 1; k >= 0; k--) begin
			diff = (depth_tbl[b] >= depth_tbl[a]) ?
				int'(depth_tbl[b]) - int'(depth_tbl[a]) : 0;
			if ((1 << k) <= diff) begin
				up = lift_tbl[k][b];
				if (depth_tbl[a] <= depth_tbl[up])
					b = up;
			end
		end
		// Climb both nodes while their ancestors still differ.
		for (k = lcal_pkg::LEVELS - 1; k >= 0 && a != b; k--) begin
			if (lift_tbl[k][a] != lift_tbl[k][b]) begin
				a = lift_tbl[k][a];
				b = lift_tbl[k][b];
			end
		end
		if (a != b)
			a = lift_tbl[0][a];
		return a;
	endfunction

	// Applies one accepted command to the predictor; a query leaves an answer.
	function automatic void apply_cmd(input lca_cmd_t c);
		int unsigned last;
		int          k;
		int          n;
		case (c.cmd)
			lcal_pkg::CMD_LOAD: begin
				// A load of the null node, or beyond the table, changes nothing.
				if (c.node != 0 && int'(c.node) <= lcal_pkg::MAX_NODES) begin
					lift_tbl[0][c.node] = null_if_out(c.parent);
					depth_tbl[c.node]   = c.depth;
				end
			end
			lcal_pkg::CMD_BUILD: begin
				last = (node_limit > lcal_pkg::MAX_NODES) ? lcal_pkg::MAX_NODES : node_limit;
				for (k = 1; k < lcal_pkg::LEVELS; k++)
					for (n = 1; n <= int'(last); n++)
						lift_tbl[k][n] = lift_tbl[k-1][lift_tbl[k-1][n]];
			end
			lcal_pkg::CMD_QUERY: begin
				expected_lca = {expected_lca,
					lca_of(null_if_out(c.node), null_if_out(c.other))};
			end
			default: begin
				// The unused code is a no operation.
			end
		endcase
	endfunction

	// One line per mismatch, and every mismatch is counted.
	task automatic flag_mismatch(input string what);
		$display("%0t: mismatch: %s", $time, what);
		mismatches++;
	endtask

	// Idle length for either stream side: mostly short, now and then long. A
	// calm stretch, once it starts, holds the side busy with no idling at all.
	task automatic draw_idle(inout int calm, output int len);
		int r;
		r = $urandom_range(0, 99);
		if (calm > 0) begin
			calm--;
			len = 0;
		end else begin
			if (r < 55)
				len = 0;
			else if (r < 88)
				len = $urandom_range(1, 3);
			else if (r < 97)
				len = $urandom_range(4, 12);
			else
				len = $urandom_range(20, 60);
			if ($urandom_range(0, 49) == 0)
				calm = $urandom_range(20, 80);
		end
	endtask

	// ------------------------------------------------------------------------
	// Driver: takes the next pending command once the previous transfer has
	// happened, after a random gap. The predictor sees a command at the edge
	// where its transfer takes place, which is also the order the block sees.
	// ------------------------------------------------------------------------
	lca_cmd_t in_flight;
	int       drv_gap;
	int       drv_calm;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			drv_gap  = 0;
			drv_calm = 0;
		end else begin
			if (s_tvalid && s_tready)
				apply_cmd(in_flight);
			// The stream slot is free when nothing is offered or the offer was taken.
			if (!s_tvalid || s_tready) begin
				if (drv_gap > 0) begin
					drv_gap--;
					s_tvalid <= 1'b0;
				end else if (pending_cmds.size() != 0) begin
					in_flight = pending_cmds.pop_front();
					s_tvalid  <= 1'b1;
					s_tuser   <= in_flight.cmd;
					s_tdata   <= {in_flight.other, in_flight.depth,
						in_flight.parent, in_flight.node};
					draw_idle(drv_calm, drv_gap);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: checks each result transfer against the oldest answer, and
	// stalls the result stream at random.
	// ------------------------------------------------------------------------
	lcal_pkg::node_t want;
	int              mon_stall;
	int              mon_calm;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			mon_stall = 0;
			mon_calm  = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_lca.size() == 0) begin
					flag_mismatch($sformatf("result %0d with no query outstanding", m_tdata));
				end else begin
					want = expected_lca.pop_front();
					// The ancestor sits in the low bits; the padding above must be zero.
					if (m_tdata !== {{(16 - lcal_pkg::NODE_W){1'b0}}, want})
						flag_mismatch($sformatf("ancestor got %0d expected %0d",
							m_tdata, want));
				end
			end
			if (mon_stall > 0) begin
				mon_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				draw_idle(mon_calm, mon_stall);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------------
	task automatic push_cmd(input logic [1:0] cmd, input int unsigned node,
		input int unsigned parent, input int unsigned depth, input int unsigned other);
		lca_cmd_t c;
		c.cmd    = cmd;
		c.node   = lcal_pkg::node_t'(node);
		c.parent = lcal_pkg::node_t'(parent);
		c.depth  = lcal_pkg::node_t'(depth);
		c.other  = lcal_pkg::node_t'(other);
		pending_cmds = {pending_cmds, c};
	endtask

	// Query operand: mostly a node of the tree, sometimes the null node or the
	// highest node in use.
	function automatic int unsigned pick_node(input int unsigned span);
		int r;
		r = $urandom_range(0, 99);
		if (r < 6)
			return 0;
		if (r < 14)
			return span;
		return $urandom_range(1, span);
	endfunction

	// Loads nodes 1..count as a consistent tree (every parent numbered lower,
	// so no cycle), then builds it. chain_pct biases towards long paths.
	task automatic plant_tree(input int unsigned count, input int chain_pct);
		int unsigned n;
		int unsigned p;
		plan_depth[0] = 0;
		for (n = 1; n <= count; n++) begin
			p = ($urandom_range(0, 99) < chain_pct) ? n - 1 : $urandom_range(0, n - 1);
			plan_depth[n] = (p == 0) ? 0 : plan_depth[p] + 1;
			push_cmd(lcal_pkg::CMD_LOAD, n, p, plan_depth[n], 0);
		end
		push_cmd(lcal_pkg::CMD_BUILD, 0, 0, 0, 0);
	endtask

	// Random traffic over a built tree of span nodes. Mostly queries, with
	// re-parenting loads, loads of nonsense depths, rebuilds, idle commands and
	// ignored loads of the null node mixed in. Every parent stays inside the
	// span, so nothing ever reads a table entry that was never written.
	task automatic random_mix(input int count, input int unsigned span);
		int          r;
		int unsigned n;
		int unsigned p;
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < 58) begin
				push_cmd(lcal_pkg::CMD_QUERY, pick_node(span), 0, 0, pick_node(span));
			end else if (r < 63) begin
				n = pick_node(span);
				push_cmd(lcal_pkg::CMD_QUERY, n, 0, 0, n);
			end else if (r < 71) begin
				n = $urandom_range(1, span);
				p = $urandom_range(0, n - 1);
				plan_depth[n] = (p == 0) ? 0 : plan_depth[p] + 1;
				push_cmd(lcal_pkg::CMD_LOAD, n, p, plan_depth[n], 0);
			end else if (r < 77) begin
				push_cmd(lcal_pkg::CMD_LOAD, $urandom_range(1, span), $urandom_range(0, span),
					$urandom_range(0, 1022), $urandom_range(0, 1023));
			end else if (r < 85) begin
				push_cmd(lcal_pkg::CMD_BUILD, $urandom_range(0, 1023), $urandom_range(0, 1023),
					$urandom_range(0, 1022), $urandom_range(0, 1023));
			end else if (r < 92) begin
				push_cmd(lcal_pkg::CMD_NOP, $urandom_range(0, 1023), $urandom_range(0, 1023),
					$urandom_range(0, 1022), $urandom_range(0, 1023));
			end else begin
				push_cmd(lcal_pkg::CMD_LOAD, 0, $urandom_range(0, 1023),
					$urandom_range(0, 1022), $urandom_range(0, 1023));
			end
		end
	endtask

	// Waits until every command has been taken and every answer has come, then
	// a further stretch, since a load or build leaves no result to wait for.
	task automatic drain(input int unsigned extra);
		while (pending_cmds.size() != 0 || s_tvalid || expected_lca.size() != 0)
			@(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	// Quiet time a build at the current node count may still need.
	function automatic int unsigned build_tail();
		return 3 * (lcal_pkg::LEVELS - 1) * node_limit + 100;
	endfunction

	// Register write, done only while the block is idle.
	task automatic set_node_count(input int unsigned value);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value[9:0];
		node_limit  = value & 10'h3FF;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Test sequence.
	// ------------------------------------------------------------------------
	initial begin : sequencer
		int          ph;
		int unsigned span;
		int          k;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset node count of one: a single root, the null-node load that must be
		// ignored, an idle command, and every pairing of the root with the null node.
		push_cmd(lcal_pkg::CMD_LOAD, 1, 0, 0, 0);
		push_cmd(lcal_pkg::CMD_LOAD, 0, 1023, 1022, 1023);
		push_cmd(lcal_pkg::CMD_NOP, 1023, 1023, 1022, 1023);
		push_cmd(lcal_pkg::CMD_BUILD, 0, 0, 0, 0);
		push_cmd(lcal_pkg::CMD_QUERY, 1, 0, 0, 1);
		push_cmd(lcal_pkg::CMD_QUERY, 0, 0, 0, 1);
		push_cmd(lcal_pkg::CMD_QUERY, 1, 0, 0, 0);
		push_cmd(lcal_pkg::CMD_QUERY, 0, 0, 0, 0);
		drain(build_tail());

		// A small forest: 1 with children 2 and 3, 4 under 2, 5 under 4, 6 under 3,
		// and 7 as a second root. Then a depth that contradicts the tree.
		set_node_count(7);
		push_cmd(lcal_pkg::CMD_LOAD, 1, 0, 0, 0);
		push_cmd(lcal_pkg::CMD_LOAD, 2, 1, 1, 0);
		push_cmd(lcal_pkg::CMD_LOAD, 3, 1, 1, 0);
		push_cmd(lcal_pkg::CMD_LOAD, 4, 2, 2, 0);
		push_cmd(lcal_pkg::CMD_LOAD, 5, 4, 3, 0);
		push_cmd(lcal_pkg::CMD_LOAD, 6, 3, 2, 0);
		push_cmd(lcal_pkg::CMD_LOAD, 7, 0, 0, 0);
		push_cmd(lcal_pkg::CMD_BUILD, 0, 0, 0, 0);
		push_cmd(lcal_pkg::CMD_QUERY, 5, 0, 0, 6);
		push_cmd(lcal_pkg::CMD_QUERY, 5, 0, 0, 2);
		push_cmd(lcal_pkg::CMD_QUERY, 4, 0, 0, 5);
		push_cmd(lcal_pkg::CMD_QUERY, 7, 0, 0, 5);
		push_cmd(lcal_pkg::CMD_QUERY, 6, 0, 0, 6);
		push_cmd(lcal_pkg::CMD_LOAD, 6, 3, 9, 0);
		push_cmd(lcal_pkg::CMD_QUERY, 6, 0, 0, 5);
		plan_depth[1] = 0;
		plan_depth[2] = 1;
		plan_depth[3] = 1;
		plan_depth[4] = 2;
		plan_depth[5] = 3;
		plan_depth[6] = 2;
		plan_depth[7] = 0;
		drain(build_tail());

		// A node count of zero: builds must leave the table alone, so reloaded
		// parents show up in level zero only.
		set_node_count(0);
		push_cmd(lcal_pkg::CMD_BUILD, 0, 0, 0, 0);
		random_mix(30, 7);
		drain(build_tail());

		// A single long path, so the deepest node sits at depth 512 and every
		// lifting level is used.
		set_node_count(CHAIN_NODES);
		plant_tree(CHAIN_NODES, 100);
		push_cmd(lcal_pkg::CMD_QUERY, CHAIN_NODES, 0, 0, 1);
		push_cmd(lcal_pkg::CMD_QUERY, CHAIN_NODES, 0, 0, CHAIN_NODES - 1);
		push_cmd(lcal_pkg::CMD_QUERY, 1, 0, 0, CHAIN_NODES);
		push_cmd(lcal_pkg::CMD_QUERY, 256, 0, 0, CHAIN_NODES);
		push_cmd(lcal_pkg::CMD_QUERY, 0, 0, 0, CHAIN_NODES);
		push_cmd(lcal_pkg::CMD_QUERY, CHAIN_NODES, 0, 0, CHAIN_NODES);
		for (k = 0; k < 20; k++)
			push_cmd(lcal_pkg::CMD_QUERY, pick_node(CHAIN_NODES), 0, 0,
				pick_node(CHAIN_NODES));
		drain(build_tail());

		// Random phases on small trees of random size and shape; the last one
		// returns to a node count of one.
		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0:       span = 2;
				3:       span = 1;
				1:       span = $urandom_range(3, 15);
				default: span = $urandom_range(16, 40);
			endcase
			set_node_count(span);
			plant_tree(span, $urandom_range(0, 1) ? 80 : 20);
			random_mix(20, span);
			drain(build_tail());
		end

		drain(100);
		if (mismatches == 0 && expected_lca.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Watchdog, set well beyond the slowest correct run.
	initial begin : watchdog
		#3000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire
